[hdl/irs_pkg.sv]
// Shared types, constants and helpers for the integer to radix symbol converter.
// Used by irs_alpha_check, irs_digit_div and integer_to_radix_symbols.
// No dependencies.
package irs_pkg;

    // Field and register widths.
    localparam int VALUE_W   = 32;
    localparam int MAG_W     = VALUE_W + 1;
    localparam int SYM_W     = 8;
    localparam int CFG_W     = 64;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 2;

    // Alphabet storage: sixteen byte slots over two 64-bit registers.
    localparam int ALPHA_SLOTS = 16;
    localparam int SLOT_W      = $clog2(ALPHA_SLOTS);

    // Digit limits and the nibble-serial divider layout.
    localparam int MAX_DIGITS   = 32;
    localparam int CNT_W        = $clog2(MAX_DIGITS + 1);
    localparam int NIB_W        = 4;
    localparam int DIV_STEPS    = (MAG_W + NIB_W - 1) / NIB_W;
    localparam int DIV_W        = DIV_STEPS * NIB_W;
    localparam int DIV_STEP_W   = $clog2(DIV_STEPS);

    // Default alphabet capacity.
    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int MIN_RADIX       = 2;

    // Special bytes.
    localparam logic [SYM_W-1:0] MINUS_BYTE = 8'h2D;
    localparam logic [SYM_W-1:0] PLUS_BYTE  = 8'h2B;
    localparam logic [SYM_W-1:0] ZERO_BYTE  = 8'h00;

    // Register reset values: "01234567", "89ABCDEF", decimal.
    localparam logic [CFG_W-1:0] RESET_LOW    = 64'h3736353433323130;
    localparam logic [CFG_W-1:0] RESET_HIGH   = 64'h4645444342413938;
    localparam logic [LEN_W-1:0] RESET_LENGTH = 5'd10;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYMBOLS_LOW     = 2'd0,
        CFG_SYMBOLS_HIGH    = 2'd1,
        CFG_ALPHABET_LENGTH = 2'd2
    } cfg_index_t;

    // Alphabet checker status toward the controller.
    typedef struct packed {
        logic done;
        logic ok;
    } chk_status_t;

    // Divider status toward the controller.
    typedef struct packed {
        logic push;
        logic done;
    } div_status_t;

    // Select the alphabet byte in a given slot.
    function automatic logic [SYM_W-1:0] symbol_at(
        input logic [CFG_W-1:0]  low,
        input logic [CFG_W-1:0]  high,
        input logic [SLOT_W-1:0] idx
    );
        logic [2*CFG_W-1:0] both;
        both = {high, low};
        return both[{idx, 3'b000} +: SYM_W];
    endfunction

endpackage

[hdl/irs_alpha_check.sv]
// Serial alphabet validator: one slot per cycle against all later slots in use.
// Depends on irs_pkg.
module irs_alpha_check #(
    parameter int MAX_SYMBOLS = irs_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [irs_pkg::CFG_W-1:0]       symbols_low,
    input  logic [irs_pkg::CFG_W-1:0]       symbols_high,
    input  logic [irs_pkg::LEN_W-1:0]       alphabet_length,
    output irs_pkg::chk_status_t            status
);

    localparam int SLOT_W = irs_pkg::SLOT_W;
    localparam int LEN_W  = irs_pkg::LEN_W;

    logic              busy_reg;
    logic              ok_reg;
    logic              done_reg;
    logic [SLOT_W-1:0] idx_reg;

    logic [irs_pkg::SYM_W-1:0] cur;
    logic                      bad;
    logic                      dup;
    logic                      last_idx;
    logic                      len_ok;

    // Compare the current slot with the reserved bytes and every later slot in use.
    always_comb
    begin
        cur = irs_pkg::symbol_at(symbols_low, symbols_high, idx_reg);
        bad = (cur == irs_pkg::ZERO_BYTE) || (cur == irs_pkg::MINUS_BYTE) ||
              (cur == irs_pkg::PLUS_BYTE);
        dup = 1'b0;
        for (int j = 0; j < irs_pkg::ALPHA_SLOTS; j++)
        begin
            if ((SLOT_W'(j) > idx_reg) && (LEN_W'(j) < alphabet_length) &&
                (irs_pkg::symbol_at(symbols_low, symbols_high, SLOT_W'(j)) == cur))
            begin
                dup = 1'b1;
            end
        end
        last_idx = (LEN_W'(idx_reg) + LEN_W'(1)) == alphabet_length;
        len_ok   = (alphabet_length >= LEN_W'(irs_pkg::MIN_RADIX)) &&
                   (alphabet_length <= LEN_W'(MAX_SYMBOLS));
    end

    // Scan sequencer; a length out of range finishes at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ok_reg   <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= len_ok;
            ok_reg   <= len_ok;
            done_reg <= !len_ok;
            idx_reg  <= '0;
        end
        else if (busy_reg)
        begin
            ok_reg <= ok_reg && !bad && !dup;
            if (last_idx)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign status.done = done_reg;
    assign status.ok   = ok_reg;

endmodule

[hdl/irs_digit_div.sv]
// Nibble-serial divider by the radix: one digit per pass over the nibbles, least
// significant first, with the quotient shifted back into the same register.
// Depends on irs_pkg.
module irs_digit_div #(
    parameter int MAX_SYMBOLS = irs_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [irs_pkg::MAG_W-1:0]            magnitude,
    input  logic [$clog2(MAX_SYMBOLS + 1)-1:0]   radix,
    output logic [$clog2(MAX_SYMBOLS)-1:0]       digit,
    output irs_pkg::div_status_t                 status
);

    localparam int REM_W  = $clog2(MAX_SYMBOLS);
    localparam int T_W    = REM_W + 1;
    localparam int SH_W   = irs_pkg::DIV_W;
    localparam int NIB_W  = irs_pkg::NIB_W;
    localparam int STEP_W = irs_pkg::DIV_STEP_W;
    localparam int CNT_W  = irs_pkg::CNT_W;

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  ndig_reg;
    logic [SH_W-1:0]   shift_reg;
    logic [REM_W-1:0]  rem_reg;
    logic              qnz_reg;

    logic [NIB_W-1:0] nib;
    logic [NIB_W-1:0] qbits;
    logic [T_W-1:0]   t;
    logic [REM_W-1:0] r;
    logic             last_step;
    logic             q_nonzero;
    logic [CNT_W-1:0] ndig_inc;
    logic             push;
    logic             finish;

    // Four restoring division steps on the top nibble.
    always_comb
    begin
        nib = shift_reg[SH_W-1 -: NIB_W];
        r   = rem_reg;
        t   = '0;
        for (int b = NIB_W - 1; b >= 0; b--)
        begin
            t = {r, nib[b]};
            if (t >= T_W'(radix))
            begin
                qbits[b] = 1'b1;
                t        = t - T_W'(radix);
            end
            else
            begin
                qbits[b] = 1'b0;
            end
            r = t[REM_W-1:0];
        end
        last_step = step_reg == STEP_W'(irs_pkg::DIV_STEPS - 1);
        q_nonzero = qnz_reg || (|qbits);
        ndig_inc  = ndig_reg + CNT_W'(1);
        push      = busy_reg && last_step;
        finish    = push && (!q_nonzero || (ndig_inc == CNT_W'(irs_pkg::MAX_DIGITS)));
    end

    // Pass and digit counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            ndig_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            ndig_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (last_step)
            begin
                step_reg <= '0;
                ndig_reg <= ndig_inc;
                if (finish)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    // Dividend and quotient shift register with the running remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= SH_W'(magnitude);
            rem_reg   <= '0;
            qnz_reg   <= 1'b0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[SH_W-NIB_W-1:0], qbits};
            if (last_step)
            begin
                rem_reg <= '0;
                qnz_reg <= 1'b0;
            end
            else
            begin
                rem_reg <= r;
                qnz_reg <= q_nonzero;
            end
        end
    end

    assign digit       = r;
    assign status.push = push;
    assign status.done = finish;

endmodule

[hdl/integer_to_radix_symbols.sv]
// Top level of the integer to radix symbol converter: configuration registers,
// control sequencer, digit stack and output register.
// Depends on irs_pkg, irs_alpha_check and irs_digit_div.
//
// Usage:
//   Input channel (in_valid, in_stall, value) takes one signed 32-bit item.
//   Output channel (out_valid, out_stall, symbol, last) returns the symbols of
//   that value, most significant first, after a '-' for negative values; last
//   marks the final symbol. An invalid alphabet gives no output for the item.
//   Configuration is written through cfg_write, cfg_index and cfg_data while
//   the block is idle; index 0 and 1 hold the alphabet bytes, index 2 its length.
// Timing:
//   One item at a time. The divider works out the digits, one per pass, while
//   the alphabet scan runs beside it; when both are done the symbols are
//   handed out, with the sign first for a negative value.
//   An invalid alphabet still lets the division run out; a length of 0 or 1
//   can keep it going for all 32 digit passes.
//   The next item is taken as soon as the last symbol sits in the output
//   register.
// Reset restores the decimal alphabet "0123456789ABCDEF" with length 10 and
// empties the block. While out_stall is high with a valid symbol, the output
// register holds that symbol and the emit state waits.
module integer_to_radix_symbols #(
    parameter int MAX_SYMBOLS = irs_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [irs_pkg::VALUE_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [irs_pkg::SYM_W-1:0]         symbol,
    output logic                              last,
    input  logic                              cfg_write,
    input  logic [irs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [irs_pkg::CFG_W-1:0]         cfg_data
);

    localparam int DIGIT_W    = $clog2(MAX_SYMBOLS);
    localparam int RAD_W      = $clog2(MAX_SYMBOLS + 1);
    localparam int MAG_W      = irs_pkg::MAG_W;
    localparam int CNT_W      = irs_pkg::CNT_W;
    localparam int MAX_DIGITS = irs_pkg::MAX_DIGITS;
    localparam int SYM_W      = irs_pkg::SYM_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_EMIT
    } state_t;

    // Configuration registers.
    logic [irs_pkg::CFG_W-1:0] symbols_low_reg;
    logic [irs_pkg::CFG_W-1:0] symbols_high_reg;
    logic [irs_pkg::LEN_W-1:0] alphabet_length_reg;

    // Sequencer state and output register.
    state_t             state_reg, state_next;
    logic               neg_reg, neg_next;
    logic               sign_reg, sign_next;
    logic               chk_done_reg, chk_done_next;
    logic               chk_ok_reg, chk_ok_next;
    logic               div_done_reg, div_done_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]   symbol_reg, symbol_next;
    logic               last_reg, last_next;

    // Digit stack: push shifts up, pop shifts down, top sits in entry 0.
    logic [DIGIT_W-1:0] stack_reg [MAX_DIGITS];
    logic [DIGIT_W-1:0] stack_next [MAX_DIGITS];

    logic                 accept;
    logic                 out_free;
    logic [MAG_W-1:0]     sext;
    logic [MAG_W-1:0]     mag;
    logic [DIGIT_W-1:0]   digit;
    irs_pkg::chk_status_t chk_stat;
    irs_pkg::div_status_t div_stat;

    // Register writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbols_low_reg     <= irs_pkg::RESET_LOW;
            symbols_high_reg    <= irs_pkg::RESET_HIGH;
            alphabet_length_reg <= irs_pkg::RESET_LENGTH;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                irs_pkg::CFG_SYMBOLS_LOW:     symbols_low_reg  <= cfg_data;
                irs_pkg::CFG_SYMBOLS_HIGH:    symbols_high_reg <= cfg_data;
                irs_pkg::CFG_ALPHABET_LENGTH:
                    alphabet_length_reg <= cfg_data[irs_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input handshake and the widened magnitude.
    assign in_stall = state_reg != ST_IDLE;
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        sext = {value[irs_pkg::VALUE_W-1], value};
        mag  = value[irs_pkg::VALUE_W-1] ? (~sext + MAG_W'(1)) : sext;
    end

    irs_alpha_check #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (accept),
        .symbols_low     (symbols_low_reg),
        .symbols_high    (symbols_high_reg),
        .alphabet_length (alphabet_length_reg),
        .status          (chk_stat)
    );

    irs_digit_div #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .magnitude (mag),
        .radix     (alphabet_length_reg[RAD_W-1:0]),
        .digit     (digit),
        .status    (div_stat)
    );

    // Sequencer: start check and division together, await both, emit or drop.
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        sign_next      = sign_reg;
        chk_done_next  = chk_done_reg;
        chk_ok_next    = chk_ok_reg;
        div_done_next  = div_done_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            stack_next[i] = stack_reg[i];
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_WORK;
                    neg_next      = value[irs_pkg::VALUE_W-1];
                    chk_done_next = 1'b0;
                    div_done_next = 1'b0;
                    count_next    = '0;
                end
            end
            ST_WORK:
            begin
                if (div_stat.push)
                begin
                    stack_next[0] = digit;
                    for (int i = 1; i < MAX_DIGITS; i++)
                    begin
                        stack_next[i] = stack_reg[i-1];
                    end
                    count_next = count_reg + CNT_W'(1);
                end
                if (chk_stat.done)
                begin
                    chk_done_next = 1'b1;
                    chk_ok_next   = chk_stat.ok;
                end
                if (div_stat.done)
                begin
                    div_done_next = 1'b1;
                end
                if (chk_done_reg && div_done_reg)
                begin
                    if (chk_ok_reg)
                    begin
                        state_next = ST_EMIT;
                        sign_next  = neg_reg;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        symbol_next = irs_pkg::MINUS_BYTE;
                        last_next   = 1'b0;
                        sign_next   = 1'b0;
                    end
                    else
                    begin
                        symbol_next = irs_pkg::symbol_at(symbols_low_reg, symbols_high_reg,
                                                         irs_pkg::SLOT_W'(stack_reg[0]));
                        last_next   = count_reg == CNT_W'(1);
                        for (int i = 0; i < MAX_DIGITS - 1; i++)
                        begin
                            stack_next[i] = stack_reg[i+1];
                        end
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            neg_reg       <= 1'b0;
            sign_reg      <= 1'b0;
            chk_done_reg  <= 1'b0;
            chk_ok_reg    <= 1'b0;
            div_done_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            symbol_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            sign_reg      <= sign_next;
            chk_done_reg  <= chk_done_next;
            chk_ok_reg    <= chk_ok_next;
            div_done_reg  <= div_done_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            symbol_reg    <= symbol_next;
            last_reg      <= last_next;
        end
    end

    // Digit stack storage.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            stack_reg[i] <= stack_next[i];
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;

    // The stack never runs empty while symbols are being handed out.
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> count_reg != '0)
        else $error("emit state with an empty digit stack");

    // Digits arrive only while working and never overflow the stack.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.push |-> (state_reg == ST_WORK) && (count_reg < CNT_W'(MAX_DIGITS)))
        else $error("digit pushed outside work or into a full stack");

    // An accepted item always starts the work phase.
    a_accept_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_WORK)
        else $error("accepted item did not start work");

    // A new output item appears only from the emit state.
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("output item raised outside the emit state");

endmodule

[tb/irs_checker.sv]
// Scoreboard for the integer to radix symbol converter: shadows the configuration
// registers, predicts the symbol run of every accepted value and compares results.
// Depends on irs_pkg.
`timescale 1ns / 1ps

module irs_checker #(
    parameter int MAX_SYMBOLS = irs_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic signed [irs_pkg::VALUE_W-1:0] value,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [irs_pkg::SYM_W-1:0]          symbol,
    input  logic                               last,
    input  logic                               cfg_write,
    input  logic [irs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [irs_pkg::CFG_W-1:0]          cfg_data,
    output int                                 fail_count,
    output int                                 outstanding
);
    import irs_pkg::*;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } sym_item_t;

    // Shadow copy of the alphabet registers.
    logic [CFG_W-1:0] alpha_lo;
    logic [CFG_W-1:0] alpha_hi;
    logic [LEN_W-1:0] alpha_len;

    // Symbols still owed by the block, oldest first.
    sym_item_t pending_syms[$];
    int        errors;

    function automatic logic [SYM_W-1:0] alpha_byte(input int slot);
        logic [CFG_W-1:0] word;
        word = (slot < 8) ? (alpha_lo >> (8 * slot)) : (alpha_hi >> (8 * (slot - 8)));
        return word[SYM_W-1:0];
    endfunction

    // An alphabet is usable when its length is in range and every symbol in use
    // is distinct and is neither a sign nor a zero byte.
    function automatic bit alphabet_usable();
        logic [SYM_W-1:0] s;
        if (alpha_len < MIN_RADIX || alpha_len > MAX_SYMBOLS || alpha_len > ALPHA_SLOTS)
            return 1'b0;
        for (int i = 0; i < alpha_len; i++)
        begin
            s = alpha_byte(i);
            if (s == ZERO_BYTE || s == MINUS_BYTE || s == PLUS_BYTE)
                return 1'b0;
            for (int j = i + 1; j < alpha_len; j++)
            begin
                if (alpha_byte(j) == s)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Queue the sign and digit symbols that one value turns into.
    task automatic predict_symbols(input logic signed [VALUE_W-1:0] v);
        logic [MAG_W-1:0]  mag;
        logic [MAG_W-1:0]  wrap;
        logic [SLOT_W-1:0] digits [MAX_DIGITS];
        int                count;
        if (!alphabet_usable())
            return;
        mag = {1'b0, v};
        if (v[VALUE_W-1])
        begin
            // Widened magnitude so the most negative value stays exact.
            wrap = '0;
            wrap[VALUE_W] = 1'b1;
            mag = wrap - mag;
            pending_syms.push_back('{symbol: MINUS_BYTE, last: 1'b0});
        end
        count = 0;
        do
        begin
            digits[count] = SLOT_W'(mag % alpha_len);
            mag = mag / alpha_len;
            count++;
        end
        while (mag != 0 && count < MAX_DIGITS);
        for (int i = count - 1; i >= 0; i--)
            pending_syms.push_back('{symbol: alpha_byte(digits[i]), last: (i == 0)});
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        sym_item_t want;
        if (!rst_n)
        begin
            alpha_lo  = RESET_LOW;
            alpha_hi  = RESET_HIGH;
            alpha_len = RESET_LENGTH;
            pending_syms.delete();
            errors = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Follow register writes; unknown indexes change nothing.
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SYMBOLS_LOW:     alpha_lo  = cfg_data;
                    CFG_SYMBOLS_HIGH:    alpha_hi  = cfg_data;
                    CFG_ALPHABET_LENGTH: alpha_len = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                predict_symbols(value);

            // Compare each accepted symbol with the oldest one owed.
            if (out_valid && !out_stall)
            begin
                if (pending_syms.size() == 0)
                begin
                    $display("%0t: unexpected item, actual symbol %h last %b",
                             $time, symbol, last);
                    errors++;
                end
                else
                begin
                    want = pending_syms.pop_front();
                    if (symbol !== want.symbol)
                    begin
                        $display("%0t: symbol mismatch, expected %h, actual %h",
                                 $time, want.symbol, symbol);
                        errors++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last mismatch, expected %b, actual %b",
                                 $time, want.last, last);
                        errors++;
                    end
                end
            end
            fail_count  <= errors;
            outstanding <= pending_syms.size();
        end
    end

endmodule

[tb/integer_to_radix_symbols_tb.sv]
// Testbench top for the integer to radix symbol converter: clock, reset, stimulus,
// alphabet programming, random idling and the final verdict.
// Depends on irs_pkg, integer_to_radix_symbols and irs_checker.
`timescale 1ns / 1ps

module integer_to_radix_symbols_tb;
    import irs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [VALUE_W-1:0]   VALUE_MAX  = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0]   VALUE_MIN  = 32'h8000_0000;
    localparam logic [SYM_W-1:0]     DIGIT_ZERO = 8'h30;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int BLOCKS         = 4;
    localparam int BLOCK_ITEMS    = 40;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [VALUE_W-1:0] value;
    logic                      out_valid;
    logic                      out_stall;
    logic [SYM_W-1:0]          symbol;
    logic                      last;
    logic                      cfg_write;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    int                        fail_count;
    int                        outstanding;

    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    // Alphabet being programmed by the random part.
    logic [SYM_W-1:0] alpha_bytes [ALPHA_SLOTS];
    int               alpha_count;

    integer_to_radix_symbols uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .symbol    (symbol),
        .last      (last),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    irs_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .symbol      (symbol),
        .last        (last),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Receiver back-pressure.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one value, after a random gap, and hold it until accepted.
    task automatic send_item(input logic [VALUE_W-1:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait until the block is idle and every owed symbol has
    // come, then some extra cycles. The first edge lets the owed count catch up
    // with the item accepted last.
    task automatic settle(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || in_stall)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_alphabet(
        input logic [CFG_W-1:0] lo,
        input logic [CFG_W-1:0] hi,
        input logic [LEN_W-1:0] len
    );
        logic [CFG_W-1:0] length_word;
        length_word = {$urandom, $urandom};
        length_word[LEN_W-1:0] = len;
        cfg_write <= 1'b1;
        cfg_index <= CFG_SYMBOLS_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_SYMBOLS_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= CFG_ALPHABET_LENGTH;
        cfg_data  <= length_word;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic apply_alphabet();
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        for (int i = 0; i < 8; i++)
        begin
            lo[8*i +: 8] = alpha_bytes[i];
            hi[8*i +: 8] = alpha_bytes[i + 8];
        end
        write_alphabet(lo, hi, LEN_W'(alpha_count));
    endtask

    // Distinct legal symbols in use; the unused slots get arbitrary bytes.
    task automatic random_alphabet();
        bit [255:0]       taken;
        logic [SYM_W-1:0] b;
        int               pick;
        taken = '0;
        pick = $urandom_range(0, 3);
        alpha_count = (pick == 0) ? MIN_RADIX :
                      (pick == 1) ? ALPHA_SLOTS : $urandom_range(3, ALPHA_SLOTS - 1);
        for (int i = 0; i < ALPHA_SLOTS; i++)
        begin
            b = $urandom_range(0, 255);
            if (i < alpha_count)
            begin
                while (b == ZERO_BYTE || b == MINUS_BYTE || b == PLUS_BYTE || taken[b])
                    b = $urandom_range(0, 255);
                taken[b] = 1'b1;
            end
            alpha_bytes[i] = b;
        end
    endtask

    // Spoil a legal alphabet in one of the ways that silences the block.
    task automatic spoil_alphabet();
        int a;
        int b;
        a = $urandom_range(0, alpha_count - 1);
        case ($urandom_range(0, 3))
            0: alpha_count = $urandom_range(0, MIN_RADIX - 1);
            1: alpha_count = $urandom_range(ALPHA_SLOTS + 1, 31);
            2:
            begin
                case ($urandom_range(0, 2))
                    0: alpha_bytes[a] = ZERO_BYTE;
                    1: alpha_bytes[a] = MINUS_BYTE;
                    default: alpha_bytes[a] = PLUS_BYTE;
                endcase
            end
            default:
            begin
                b = $urandom_range(0, alpha_count - 1);
                if (b == a)
                    b = (a + 1) % alpha_count;
                alpha_bytes[b] = alpha_bytes[a];
            end
        endcase
    endtask

    // Values weighted toward digit-count boundaries and the extremes.
    function automatic logic [VALUE_W-1:0] pick_value(input int radix);
        longint lv;
        longint p;
        int     k;
        lv = 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: lv = longint'($urandom);
            4: lv = longint'($urandom_range(0, 600)) - 300;
            5: lv = longint'(VALUE_MIN) + $urandom_range(0, 3);
            6: lv = longint'(VALUE_MAX) - $urandom_range(0, 3);
            7:
            begin
                p = 1;
                k = $urandom_range(1, 31);
                repeat (k)
                begin
                    if (p * radix <= longint'(VALUE_MAX))
                        p = p * radix;
                end
                lv = p + longint'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1))
                    lv = -lv;
            end
            8:
            begin
                lv = longint'($urandom >> $urandom_range(0, 31));
                if ($urandom_range(0, 1))
                    lv = -lv;
            end
            default: lv = longint'($urandom_range(0, 2)) - 1;
        endcase
        return VALUE_W'(lv);
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        value         = '0;
        out_stall     = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_SYMBOLS_LOW;
        cfg_data      = '0;
        send_idle_pct = 17;
        recv_idle_pct = 61;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Decimal alphabet from reset: zero, signs, digit-count edges, extremes.
        send_item(32'd0);
        send_item(32'hFFFF_FFFF);
        send_item(32'd9);
        send_item(32'd10);
        send_item(VALUE_MAX);
        send_item(VALUE_MIN);

        // A write to an unknown index must leave the alphabet alone.
        settle(DRAIN_CYCLES);
        cfg_write <= 1'b1;
        cfg_index <= CFG_UNUSED;
        cfg_data  <= '1;
        @(posedge clk);
        cfg_write <= 1'b0;
        send_item(32'd100);

        // Full hexadecimal alphabet.
        settle(DRAIN_CYCLES);
        write_alphabet(RESET_LOW, RESET_HIGH, LEN_W'(ALPHA_SLOTS));
        send_item(VALUE_MAX);
        send_item(32'hFFFF_FFFF);

        // Binary: the most negative value gives the longest run.
        settle(DRAIN_CYCLES);
        write_alphabet(64'h0000_0000_0000_3130, '0, LEN_W'(MIN_RADIX));
        send_item(VALUE_MIN);
        send_item(VALUE_MAX);

        // Signs, zero bytes and repeats beyond the length are ignored.
        settle(DRAIN_CYCLES);
        write_alphabet(RESET_LOW, 64'h0000_2B00_2D2D_3938, 5'd10);
        send_item(-32'sd12345);

        // Alphabets that give no output.
        settle(DRAIN_CYCLES);
        write_alphabet(RESET_LOW, RESET_HIGH, 5'd0);
        send_item(32'd5);
        settle(DRAIN_CYCLES);
        write_alphabet(RESET_LOW, RESET_HIGH, 5'd1);
        send_item(32'd5);
        settle(DRAIN_CYCLES);
        write_alphabet(RESET_LOW, RESET_HIGH, 5'd17);
        send_item(32'd5);
        settle(DRAIN_CYCLES);
        write_alphabet(RESET_LOW, RESET_HIGH, 5'd31);
        send_item(32'd5);
        settle(DRAIN_CYCLES);
        write_alphabet(64'h3736_3534_2B32_3130, RESET_HIGH, 5'd10);
        send_item(32'd5);
        settle(DRAIN_CYCLES);
        write_alphabet(RESET_LOW, {MINUS_BYTE, RESET_HIGH[55:0]}, LEN_W'(ALPHA_SLOTS));
        send_item(32'd5);
        settle(DRAIN_CYCLES);
        write_alphabet({RESET_LOW[63:8], ZERO_BYTE}, RESET_HIGH, 5'd10);
        send_item(32'd5);
        settle(DRAIN_CYCLES);
        write_alphabet(RESET_LOW, {RESET_HIGH[63:16], DIGIT_ZERO, RESET_HIGH[7:0]}, 5'd10);
        send_item(32'd5);

        // Random part: three idling profiles, several alphabets in each.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 61 : 0;
            recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 17 : 0;
            for (int blk = 0; blk < BLOCKS; blk++)
            begin
                settle(DRAIN_CYCLES);
                random_alphabet();
                apply_alphabet();
                for (int n = 0; n < BLOCK_ITEMS; n++)
                begin
                    // Hold off once until the block has emptied completely.
                    if (blk == 0 && n == BLOCK_ITEMS / 2)
                        settle(0);
                    send_item(pick_value(alpha_count));
                end
            end
            settle(DRAIN_CYCLES);
            random_alphabet();
            spoil_alphabet();
            apply_alphabet();
            repeat (3) send_item(pick_value(MIN_RADIX));
        end

        settle(DRAIN_CYCLES);
        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
hdl/irs_pkg.sv
hdl/irs_alpha_check.sv
hdl/irs_digit_div.sv
hdl/integer_to_radix_symbols.sv
tb/irs_checker.sv
tb/integer_to_radix_symbols_tb.sv
